FILE: design/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, codes and fixed-point helpers of the swept box collision clamp.
// ----------------------------------------------------------------------------
package swc_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int SIZE_W  = 20;
    localparam int DELTA_W = 17;
    localparam int IDX_W   = 4;
    localparam int KIND_W  = 2;
    localparam int SKIP_N  = 16;
    localparam int FRAC_W  = 8;

    // internal coordinate width, wide enough for position + size + delta sums
    localparam int COORD_W = 28;

    typedef logic signed [COORD_W-1:0] coord_t;

    // item codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic AXIS_H    = 1'b0;
    localparam logic AXIS_V    = 1'b1;

    // entry kinds; the remaining code behaves as empty
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOLID  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ONEWAY = 2'd2;

    // saturation limits of the result delta
    localparam coord_t DELTA_MAX_C = coord_t'(65535);
    localparam coord_t DELTA_MIN_C = coord_t'(-65536);

    // geometry and kind of one table entry
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
        logic [KIND_W-1:0]       kind;
    } entry_t;

    // registered table read
    typedef struct packed {
        logic   vld;
        logic   written;
        entry_t ent;
    } tbl_rd_t;

    // mover and trail bounds, fixed for the length of one query
    typedef struct packed {
        coord_t t_x0;
        coord_t t_x1;
        coord_t t_y0;
        coord_t t_y1;
        coord_t m_x0;
        coord_t m_x1;
        coord_t m_y0;
        coord_t m_y1;
        coord_t near;
        coord_t far;
    } geom_t;

    // per-entry verdict from the evaluation pipe
    typedef struct packed {
        logic   vld;
        logic   active;
        logic   oneway;
        logic   lmatch;
        logic   skip;
        logic   hit_trail;
        logic   hit_mover;
        coord_t c_neg;
        coord_t c_pos;
    } eval_res_t;

    function automatic coord_t sx_pos(input logic [POS_W-1:0] v);
        return {{(COORD_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic coord_t zx_size(input logic [SIZE_W-1:0] v);
        return {{(COORD_W-SIZE_W){1'b0}}, v};
    endfunction

    function automatic coord_t sx_delta(input logic [DELTA_W-1:0] v);
        return {{(COORD_W-DELTA_W){v[DELTA_W-1]}}, v};
    endfunction

    // floor to a whole unit: clear the fraction
    function automatic coord_t flo(input coord_t v);
        return {v[COORD_W-1:FRAC_W], {FRAC_W{1'b0}}};
    endfunction

endpackage

FILE: design/swc_table.sv
// ----------------------------------------------------------------------------
// swc_table
// Entry table: one write port, one registered read port, per-entry written flags.
// ----------------------------------------------------------------------------
module swc_table
    import swc_pkg::*;
#(
    parameter int MAX_BODIES = 16,
    parameter int LAYER_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] wr_addr,
    input  entry_t                          wr_ent,
    input  logic [LAYER_BITS-1:0]           wr_layer,
    input  logic [LAYER_BITS-1:0]           wr_mask,
    input  logic                            rd_en,
    input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_addr,
    output tbl_rd_t                         rd,
    output logic [LAYER_BITS-1:0]           rd_layer,
    output logic [LAYER_BITS-1:0]           rd_mask,
    output logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_idx
);

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

    entry_t                mem_ent   [MAX_BODIES];
    logic [LAYER_BITS-1:0] mem_layer [MAX_BODIES];
    logic [LAYER_BITS-1:0] mem_mask  [MAX_BODIES];
    logic [MAX_BODIES-1:0] written_reg;
    logic                  rd_vld_reg;
    logic                  rd_written_reg;
    entry_t                rd_ent_reg;
    logic [LAYER_BITS-1:0] rd_layer_reg;
    logic [LAYER_BITS-1:0] rd_mask_reg;
    logic [AW-1:0]         rd_idx_reg;

    // payload memory write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_ent[wr_addr]   <= wr_ent;
            mem_layer[wr_addr] <= wr_layer;
            mem_mask[wr_addr]  <= wr_mask;
        end
    end

    // written flags, an unwritten entry reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_ent_reg     <= mem_ent[rd_addr];
        rd_layer_reg   <= mem_layer[rd_addr];
        rd_mask_reg    <= mem_mask[rd_addr];
        rd_written_reg <= written_reg[rd_addr];
        rd_idx_reg     <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
    end

    assign rd.vld     = rd_vld_reg;
    assign rd.written = rd_written_reg;
    assign rd.ent     = rd_ent_reg;
    assign rd_layer   = rd_layer_reg;
    assign rd_mask    = rd_mask_reg;
    assign rd_idx     = rd_idx_reg;

endmodule

FILE: design/swc_eval.sv
// ----------------------------------------------------------------------------
// swc_eval
// Shared two-stage entry evaluator: edge sums, then overlap tests and clamp
// candidates, one table entry per cycle.
// ----------------------------------------------------------------------------
module swc_eval
    import swc_pkg::*;
#(
    parameter int MAX_BODIES = 16,
    parameter int LAYER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tbl_rd_t               rd,
    input  logic [LAYER_BITS-1:0] rd_layer,
    input  logic [LAYER_BITS-1:0] rd_mask,
    input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_idx,
    input  geom_t                 geom,
    input  logic                  axis,
    input  logic [LAYER_BITS-1:0] mv_layer,
    input  logic [LAYER_BITS-1:0] mv_mask,
    input  logic [SKIP_N-1:0]     skip_set,
    output eval_res_t             res,
    output logic                  busy
);

    logic   a_vld_reg;
    logic   a_active_reg;
    logic   a_oneway_reg;
    logic   a_lmatch_reg;
    logic   a_skip_reg;
    coord_t a_x0_reg;
    coord_t a_x1_reg;
    coord_t a_y0_reg;
    coord_t a_y1_reg;
    coord_t a_far_reg;
    coord_t a_near_reg;

    logic   b_vld_reg;
    logic   b_active_reg;
    logic   b_oneway_reg;
    logic   b_lmatch_reg;
    logic   b_skip_reg;
    logic   b_trail_reg;
    logic   b_mover_reg;
    coord_t b_neg_reg;
    coord_t b_pos_reg;

    coord_t ex_f;
    coord_t ey_f;
    logic   in_skip_range;

    assign ex_f          = flo(sx_pos(rd.ent.x));
    assign ey_f          = flo(sx_pos(rd.ent.y));
    assign in_skip_range = (32'(rd_idx) < 32'(SKIP_N));

    // stage a: floored entry edges, raw far edge, match flags
    always_ff @(posedge aclk) begin
        a_active_reg <= rd.written
                        && (rd.ent.kind == KIND_SOLID || rd.ent.kind == KIND_ONEWAY);
        a_oneway_reg <= (rd.ent.kind == KIND_ONEWAY);
        a_lmatch_reg <= ((mv_mask & rd_layer) | (mv_layer & rd_mask)) != '0;
        a_skip_reg   <= in_skip_range && skip_set[4'(rd_idx)];
        a_x0_reg     <= ex_f;
        a_x1_reg     <= ex_f + flo(zx_size(rd.ent.w));
        a_y0_reg     <= ey_f;
        a_y1_reg     <= ey_f + flo(zx_size(rd.ent.h));
        if (axis == AXIS_H) begin
            a_far_reg  <= sx_pos(rd.ent.x) + zx_size(rd.ent.w);
            a_near_reg <= ex_f;
        end else begin
            a_far_reg  <= sx_pos(rd.ent.y) + zx_size(rd.ent.h);
            a_near_reg <= ey_f;
        end
    end

    // stage b: strict overlap tests and the two clamp candidates
    always_ff @(posedge aclk) begin
        b_active_reg <= a_active_reg;
        b_oneway_reg <= a_oneway_reg;
        b_lmatch_reg <= a_lmatch_reg;
        b_skip_reg   <= a_skip_reg;
        b_trail_reg  <= (geom.t_x0 < a_x1_reg) && (geom.t_x1 > a_x0_reg)
                        && (geom.t_y0 < a_y1_reg) && (geom.t_y1 > a_y0_reg);
        b_mover_reg  <= (geom.m_x0 < a_x1_reg) && (geom.m_x1 > a_x0_reg)
                        && (geom.m_y0 < a_y1_reg) && (geom.m_y1 > a_y0_reg);
        b_neg_reg    <= flo(a_far_reg) - geom.near;
        b_pos_reg    <= a_near_reg - geom.far;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= rd.vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    assign res.vld       = b_vld_reg;
    assign res.active    = b_active_reg;
    assign res.oneway    = b_oneway_reg;
    assign res.lmatch    = b_lmatch_reg;
    assign res.skip      = b_skip_reg;
    assign res.hit_trail = b_trail_reg;
    assign res.hit_mover = b_mover_reg;
    assign res.c_neg     = b_neg_reg;
    assign res.c_pos     = b_pos_reg;
    assign busy          = a_vld_reg || b_vld_reg;

endmodule

FILE: design/swept_box_collision_clamp.sv
// ----------------------------------------------------------------------------
// swept_box_collision_clamp
// Box table with a swept-box query that clamps a move against matching entries.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------
//   s_      | in  | s_valid / s_ready  | cmd, entry, box, layers, axis, delta
//   m_      | out | m_valid / m_ready  | allowed_delta, blocked, was_query
//
// A write beat goes from accept through the acknowledge state to the result
// load. A query beat runs two set-up states, one table read per entry through
// the shared evaluator, a drain state until its pipe is empty, one result state.
// s_ready is high only while idle, at best the cycle after the result loads.
// A result still waiting in the output register holds the next in its last state.
// Reset clears the sequencer, the output valid and the entry written flags.
// ----------------------------------------------------------------------------
module swept_box_collision_clamp
    import swc_pkg::*;
#(
    parameter int MAX_BODIES = 16,
    parameter int LAYER_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic signed [POS_W-1:0]  s_box_x,
    input  logic signed [POS_W-1:0]  s_box_y,
    input  logic [SIZE_W-1:0]        s_box_width,
    input  logic [SIZE_W-1:0]        s_box_height,
    input  logic [LAYER_BITS-1:0]    s_layer_bits,
    input  logic [LAYER_BITS-1:0]    s_mask_bits,
    input  logic [KIND_W-1:0]        s_entry_kind_in,
    input  logic                     s_axis,
    input  logic signed [DELTA_W-1:0] s_delta,
    input  logic [SKIP_N-1:0]        s_skip_set,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DELTA_W-1:0] m_allowed_delta,
    output logic                     m_blocked,
    output logic                     m_was_query
);

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP1 = 7'b0000010,
        ST_SETUP2 = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_FIN    = 7'b0100000,
        ST_WACK   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]           cnt_reg, cnt_next;
    logic signed [POS_W-1:0] q_x_reg, q_y_reg;
    logic [SIZE_W-1:0]       q_w_reg, q_h_reg;
    logic [LAYER_BITS-1:0]   q_layer_reg, q_mask_reg;
    logic                    q_axis_reg;
    logic [DELTA_W-1:0]      q_req_reg;
    logic [SKIP_N-1:0]       q_skip_reg;
    geom_t                   geom_reg;
    coord_t                  d_reg, d_next;

    logic                    m_valid_reg, m_valid_next;
    logic [DELTA_W-1:0]      m_delta_reg;
    logic                    m_blocked_reg;
    logic                    m_query_reg;

    logic                    accept;
    logic                    wr_en;
    logic                    rd_en;
    logic                    slot_free;
    logic                    load_out;
    entry_t                  wr_ent;
    tbl_rd_t                 rd;
    logic [LAYER_BITS-1:0]   rd_layer, rd_mask;
    logic [AW-1:0]           rd_idx;
    eval_res_t               res;
    logic                    ev_busy;

    coord_t                  fx, fy, fw, fh, req_c, ad_c, sel_c;
    logic                    req_neg, req_pos;
    logic                    take;
    logic                    d_neg;
    coord_t                  d_sat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign wr_en     = accept && (s_cmd == CMD_WRITE)
                       && (32'(s_entry_index) < 32'(MAX_BODIES));
    assign rd_en     = (state_reg == ST_SCAN);
    assign slot_free = !m_valid_reg || m_ready;
    assign load_out  = slot_free && (state_reg == ST_FIN || state_reg == ST_WACK);

    assign wr_ent.x    = s_box_x;
    assign wr_ent.y    = s_box_y;
    assign wr_ent.w    = s_box_width;
    assign wr_ent.h    = s_box_height;
    assign wr_ent.kind = s_entry_kind_in;

    swc_table #(
        .MAX_BODIES (MAX_BODIES),
        .LAYER_BITS (LAYER_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (AW'(s_entry_index)),
        .wr_ent   (wr_ent),
        .wr_layer (s_layer_bits),
        .wr_mask  (s_mask_bits),
        .rd_en    (rd_en),
        .rd_addr  (cnt_reg),
        .rd       (rd),
        .rd_layer (rd_layer),
        .rd_mask  (rd_mask),
        .rd_idx   (rd_idx)
    );

    swc_eval #(
        .MAX_BODIES (MAX_BODIES),
        .LAYER_BITS (LAYER_BITS)
    ) u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd       (rd),
        .rd_layer (rd_layer),
        .rd_mask  (rd_mask),
        .rd_idx   (rd_idx),
        .geom     (geom_reg),
        .axis     (q_axis_reg),
        .mv_layer (q_layer_reg),
        .mv_mask  (q_mask_reg),
        .skip_set (q_skip_reg),
        .res      (res),
        .busy     (ev_busy)
    );

    // query capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            q_x_reg     <= s_box_x;
            q_y_reg     <= s_box_y;
            q_w_reg     <= s_box_width;
            q_h_reg     <= s_box_height;
            q_layer_reg <= s_layer_bits;
            q_mask_reg  <= s_mask_bits;
            q_axis_reg  <= s_axis;
            q_req_reg   <= s_delta;
            q_skip_reg  <= s_skip_set;
        end
    end

    // mover floors and trail start terms
    assign fx      = flo(sx_pos(q_x_reg));
    assign fy      = flo(sx_pos(q_y_reg));
    assign fw      = flo(zx_size(q_w_reg));
    assign fh      = flo(zx_size(q_h_reg));
    assign req_c   = sx_delta(q_req_reg);
    assign req_neg = q_req_reg[DELTA_W-1];
    assign req_pos = !req_neg && (q_req_reg != '0);
    assign ad_c    = req_neg ? -req_c : req_c;
    assign sel_c   = req_pos ? zx_size((q_axis_reg == AXIS_H) ? q_w_reg : q_h_reg) : req_c;

    // trail and mover bounds
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SETUP1) begin
            geom_reg.m_x0 <= fx;
            geom_reg.m_x1 <= fx + fw;
            geom_reg.m_y0 <= fy;
            geom_reg.m_y1 <= fy + fh;
            if (q_axis_reg == AXIS_H) begin
                geom_reg.t_x0 <= sx_pos(q_x_reg) + sel_c;
                geom_reg.t_x1 <= sx_pos(q_x_reg) + sel_c;
                geom_reg.t_y0 <= fy;
                geom_reg.t_y1 <= fy + fh;
                geom_reg.near <= fx;
                geom_reg.far  <= flo(sx_pos(q_x_reg) + zx_size(q_w_reg));
            end else begin
                geom_reg.t_x0 <= fx;
                geom_reg.t_x1 <= fx + fw;
                geom_reg.t_y0 <= sx_pos(q_y_reg) + sel_c;
                geom_reg.t_y1 <= sx_pos(q_y_reg) + sel_c;
                geom_reg.near <= fy;
                geom_reg.far  <= flo(sx_pos(q_y_reg) + zx_size(q_h_reg));
            end
        end else if (state_reg == ST_SETUP2) begin
            if (q_axis_reg == AXIS_H) begin
                geom_reg.t_x1 <= geom_reg.t_x0 + ad_c;
            end else begin
                geom_reg.t_y1 <= geom_reg.t_y0 + ad_c;
            end
        end
    end

    // running delta update from the evaluator verdict
    assign d_neg = d_reg[COORD_W-1];
    assign take  = res.vld && res.active && res.hit_trail && res.lmatch && !res.skip
                   && !res.hit_mover && !(res.oneway && (q_axis_reg == AXIS_H || d_neg));

    always_comb begin
        d_next = d_reg;
        if (state_reg == ST_SETUP1) begin
            d_next = req_c;
        end else if (take) begin
            if (d_neg) begin
                d_next = (res.c_neg > d_reg) ? res.c_neg : d_reg;
            end else begin
                d_next = (res.c_pos < d_reg) ? res.c_pos : d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_reg <= d_next;
    end

    // saturate to the result range
    always_comb begin
        priority if (d_reg > DELTA_MAX_C) begin
            d_sat = DELTA_MAX_C;
        end else if (d_reg < DELTA_MIN_C) begin
            d_sat = DELTA_MIN_C;
        end else begin
            d_sat = d_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = (s_cmd == CMD_QUERY) ? ST_SETUP1 : ST_WACK;
                end
            end
            ST_SETUP1: state_next = ST_SETUP2;
            ST_SETUP2: state_next = ST_SCAN;
            ST_SCAN: begin
                if (cnt_reg == AW'(MAX_BODIES - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!rd.vld && !ev_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN, ST_WACK: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (state_reg == ST_FIN) begin
                m_delta_reg   <= d_sat[DELTA_W-1:0];
                m_blocked_reg <= (d_sat != req_c);
                m_query_reg   <= 1'b1;
            end else begin
                m_delta_reg   <= '0;
                m_blocked_reg <= 1'b0;
                m_query_reg   <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_allowed_delta = m_delta_reg;
    assign m_blocked       = m_blocked_reg;
    assign m_was_query     = m_query_reg;

endmodule

FILE: design/swc_checker.sv
// ----------------------------------------------------------------------------
// swc_checker
// Port-level checks of the swept box collision clamp, bound to the top level.
// ----------------------------------------------------------------------------
module swc_checker
    import swc_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [DELTA_W-1:0] m_allowed_delta,
    input logic                      m_blocked,
    input logic                      m_was_query
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_allowed_delta)
            && $stable(m_blocked) && $stable(m_was_query))
        else $error("result beat changed while stalled");

    // the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // write acknowledgements carry no movement
    a_write_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_was_query |-> (m_allowed_delta == '0) && !m_blocked)
        else $error("write acknowledgement with nonzero payload");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind swept_box_collision_clamp swc_checker u_swc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_allowed_delta (m_allowed_delta),
    .m_blocked       (m_blocked),
    .m_was_query     (m_was_query)
);

FILE: bench/clamp_checker.sv
// ----------------------------------------------------------------------------
// clamp_checker
// Watches both channels of the swept box collision clamp, keeps its own copy
// of the box table, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module clamp_checker
    import swc_pkg::*;
#(
    parameter int MAX_BODIES = 16,
    parameter int LAYER_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [IDX_W-1:0]          s_entry_index,
    input  logic signed [POS_W-1:0]   s_box_x,
    input  logic signed [POS_W-1:0]   s_box_y,
    input  logic [SIZE_W-1:0]         s_box_width,
    input  logic [SIZE_W-1:0]         s_box_height,
    input  logic [LAYER_BITS-1:0]     s_layer_bits,
    input  logic [LAYER_BITS-1:0]     s_mask_bits,
    input  logic [KIND_W-1:0]         s_entry_kind_in,
    input  logic                      s_axis,
    input  logic signed [DELTA_W-1:0] s_delta,
    input  logic [SKIP_N-1:0]         s_skip_set,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [DELTA_W-1:0] m_allowed_delta,
    input  logic                      m_blocked,
    input  logic                      m_was_query,
    output int                        mismatches,
    output int                        pending,
    output int                        clamped
);

    typedef struct packed {
        logic signed [DELTA_W-1:0] allowed;
        logic                      blocked;
        logic                      was_query;
    } clamp_res_t;

    // shadow box table
    logic signed [POS_W-1:0]  tbl_x     [MAX_BODIES];
    logic signed [POS_W-1:0]  tbl_y     [MAX_BODIES];
    logic [SIZE_W-1:0]        tbl_w     [MAX_BODIES];
    logic [SIZE_W-1:0]        tbl_h     [MAX_BODIES];
    logic [LAYER_BITS-1:0]    tbl_layer [MAX_BODIES];
    logic [LAYER_BITS-1:0]    tbl_mask  [MAX_BODIES];
    logic [KIND_W-1:0]        tbl_kind  [MAX_BODIES];

    clamp_res_t clamp_due_q [$];
    int         miss_n  = 0;
    int         clamp_n = 0;

    // floor to a whole unit
    function automatic longint unit_floor(input longint v);
        return (v >>> FRAC_W) <<< FRAC_W;
    endfunction

    // strict rectangle overlap
    function automatic logic boxes_overlap(input longint ax, ay, aw, ah,
                                           input longint bx, by, bw, bh);
        return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
    endfunction

    // sweep the mover along the axis and clamp against matching entries
    function automatic clamp_res_t sweep_clamp(input logic axis_v,
                                               input longint bx, by, bw, bh,
                                               input logic [LAYER_BITS-1:0] lay, msk,
                                               input longint req,
                                               input logic [SKIP_N-1:0] skip);
        longint     fx, fy, fw, fh, tx, ty, tw, th, d, ex, ey, ew, eh, c, ad;
        logic       takes;
        clamp_res_t r;
        fx = unit_floor(bx);
        fy = unit_floor(by);
        fw = unit_floor(bw);
        fh = unit_floor(bh);
        ad = (req < 0) ? -req : req;
        if (axis_v == AXIS_H) begin
            tx = bx + ((req > 0) ? bw : req);
            ty = fy;
            tw = ad;
            th = fh;
        end else begin
            tx = fx;
            ty = by + ((req > 0) ? bh : req);
            tw = fw;
            th = ad;
        end
        d = req;
        for (int i = 0; i < MAX_BODIES; i++) begin
            ex = unit_floor(longint'(tbl_x[i]));
            ey = unit_floor(longint'(tbl_y[i]));
            ew = unit_floor(longint'(tbl_w[i]));
            eh = unit_floor(longint'(tbl_h[i]));
            takes = (tbl_kind[i] == KIND_SOLID || tbl_kind[i] == KIND_ONEWAY)
                 && boxes_overlap(tx, ty, tw, th, ex, ey, ew, eh)
                 && (((msk & tbl_layer[i]) | (lay & tbl_mask[i])) != '0)
                 && !(i < SKIP_N && skip[i])
                 && !boxes_overlap(fx, fy, fw, fh, ex, ey, ew, eh)
                 && !(tbl_kind[i] == KIND_ONEWAY && (axis_v == AXIS_H || d < 0));
            if (takes) begin
                if (d < 0) begin
                    if (axis_v == AXIS_H)
                        c = unit_floor(longint'(tbl_x[i]) + longint'(tbl_w[i])) - fx;
                    else
                        c = unit_floor(longint'(tbl_y[i]) + longint'(tbl_h[i])) - fy;
                    if (c > d) d = c;
                end else begin
                    if (axis_v == AXIS_H)
                        c = ex - unit_floor(bx + bw);
                    else
                        c = ey - unit_floor(by + bh);
                    if (c < d) d = c;
                end
            end
        end
        // saturate to the result width
        if (d > 65535)  d = 65535;
        if (d < -65536) d = -65536;
        r.allowed   = d[DELTA_W-1:0];
        r.blocked   = (d != req);
        r.was_query = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        miss_n++;
        $display("[%0t] MISMATCH: %0s", $realtime, msg);
    endtask

    // compare result beats, then predict accepted input beats
    always @(posedge aclk) begin
        clamp_res_t want;
        clamp_res_t ack;
        int         idx;
        if (!aresetn) begin
            clamp_due_q.delete();
            for (int i = 0; i < MAX_BODIES; i++)
                tbl_kind[i] = KIND_EMPTY;
        end else begin
            if (m_valid && m_ready) begin
                if (clamp_due_q.size() == 0) begin
                    report_mismatch("result beat with no prediction waiting");
                end else begin
                    want = clamp_due_q.pop_front();
                    if (m_allowed_delta !== want.allowed)
                        report_mismatch($sformatf("allowed_delta got %0d, want %0d",
                                                  m_allowed_delta, want.allowed));
                    if (m_blocked !== want.blocked)
                        report_mismatch($sformatf("blocked got %0b, want %0b",
                                                  m_blocked, want.blocked));
                    if (m_was_query !== want.was_query)
                        report_mismatch($sformatf("was_query got %0b, want %0b",
                                                  m_was_query, want.was_query));
                    if (want.was_query && want.blocked)
                        clamp_n++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_WRITE) begin
                    idx = int'(s_entry_index);
                    if (idx < MAX_BODIES) begin
                        tbl_x[idx]     = s_box_x;
                        tbl_y[idx]     = s_box_y;
                        tbl_w[idx]     = s_box_width;
                        tbl_h[idx]     = s_box_height;
                        tbl_layer[idx] = s_layer_bits;
                        tbl_mask[idx]  = s_mask_bits;
                        tbl_kind[idx]  = s_entry_kind_in;
                    end
                    ack.allowed   = '0;
                    ack.blocked   = 1'b0;
                    ack.was_query = 1'b0;
                    clamp_due_q   = {clamp_due_q, ack};
                end else begin
                    clamp_due_q = {clamp_due_q, sweep_clamp(s_axis,
                        longint'(s_box_x), longint'(s_box_y),
                        longint'(s_box_width), longint'(s_box_height),
                        s_layer_bits, s_mask_bits, longint'(s_delta), s_skip_set)};
                end
            end
        end
        pending    <= clamp_due_q.size();
        mismatches <= miss_n;
        clamped    <= clamp_n;
    end

endmodule

FILE: bench/swept_box_collision_clamp_test.sv
// ----------------------------------------------------------------------------
// swept_box_collision_clamp_test
// Drives table writes and sweep queries into the collision clamp with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module swept_box_collision_clamp_test
    import swc_pkg::*;
();

    localparam int UNIT        = 256;
    localparam int RAND_BEATS  = 1400;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;
    localparam int D_MAX       = 65535;
    localparam int D_MIN       = -65536;

    // the spare kind code, behaves as empty
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [7:0]                lay;
        logic [7:0]                msk;
        logic [KIND_W-1:0]         kind;
        logic                      axis;
        logic signed [DELTA_W-1:0] delta;
        logic [SKIP_N-1:0]         skip;
    } sweep_beat_t;

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic                      s_cmd           = CMD_WRITE;
    logic [IDX_W-1:0]          s_entry_index   = '0;
    logic signed [POS_W-1:0]   s_box_x         = '0;
    logic signed [POS_W-1:0]   s_box_y         = '0;
    logic [SIZE_W-1:0]         s_box_width     = '0;
    logic [SIZE_W-1:0]         s_box_height    = '0;
    logic [7:0]                s_layer_bits    = '0;
    logic [7:0]                s_mask_bits     = '0;
    logic [KIND_W-1:0]         s_entry_kind_in = KIND_EMPTY;
    logic                      s_axis          = AXIS_H;
    logic signed [DELTA_W-1:0] s_delta         = '0;
    logic [SKIP_N-1:0]         s_skip_set      = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic signed [DELTA_W-1:0] m_allowed_delta;
    logic                      m_blocked;
    logic                      m_was_query;

    int mismatches;
    int pending;
    int clamped;

    int idle_pct    = 25;
    int beats_sent  = 0;
    int writes_sent = 0;
    int sweeps_sent = 0;
    int stall_count = 0;

    swept_box_collision_clamp dut (.*);

    clamp_checker checker_i (.*);

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // beat builders
    function automatic sweep_beat_t mk_write(input int idx, x, y, w, h, lay, msk,
                                             input logic [KIND_W-1:0] kind);
        sweep_beat_t b;
        b.cmd   = CMD_WRITE;
        b.idx   = idx[IDX_W-1:0];
        b.x     = x[POS_W-1:0];
        b.y     = y[POS_W-1:0];
        b.w     = w[SIZE_W-1:0];
        b.h     = h[SIZE_W-1:0];
        b.lay   = lay[7:0];
        b.msk   = msk[7:0];
        b.kind  = kind;
        b.axis  = 1'($urandom);
        b.delta = DELTA_W'($urandom);
        b.skip  = SKIP_N'($urandom);
        return b;
    endfunction

    function automatic sweep_beat_t mk_query(input logic ax, input int x, y, w, h, lay, msk,
                                             input int delta, skip);
        sweep_beat_t b;
        b.cmd   = CMD_QUERY;
        b.idx   = IDX_W'($urandom);
        b.x     = x[POS_W-1:0];
        b.y     = y[POS_W-1:0];
        b.w     = w[SIZE_W-1:0];
        b.h     = h[SIZE_W-1:0];
        b.lay   = lay[7:0];
        b.msk   = msk[7:0];
        b.kind  = KIND_W'($urandom);
        b.axis  = ax;
        b.delta = delta[DELTA_W-1:0];
        b.skip  = skip[SKIP_N-1:0];
        return b;
    endfunction

    // coordinate inside the busy region around the origin
    function automatic int scene_pos();
        return int'($urandom_range(0, 48 * UNIT)) - 24 * UNIT;
    endfunction

    function automatic sweep_beat_t scene_write();
        logic [KIND_W-1:0] kind;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 50)      kind = KIND_SOLID;
        else if (r < 75) kind = KIND_ONEWAY;
        else if (r < 90) kind = KIND_EMPTY;
        else             kind = KIND_SPARE;
        return mk_write($urandom_range(0, 15), scene_pos(), scene_pos(),
                        $urandom_range(0, 10 * UNIT), $urandom_range(0, 10 * UNIT),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255), kind);
    endfunction

    function automatic sweep_beat_t scene_query();
        int r;
        int delta;
        int skip;
        r = $urandom_range(0, 99);
        if (r < 10)      delta = 0;
        else if (r < 15) delta = D_MAX;
        else if (r < 20) delta = D_MIN;
        else if (r < 25) delta = int'($urandom_range(0, 131071)) + D_MIN;
        else             delta = int'($urandom_range(0, 32 * UNIT)) - 16 * UNIT;
        r = $urandom_range(0, 9);
        if (r < 6)      skip = 0;
        else if (r < 9) skip = $urandom & $urandom & 16'hFFFF;
        else            skip = $urandom_range(0, 65535);
        return mk_query(1'($urandom), scene_pos(), scene_pos(),
                        $urandom_range(0, 4 * UNIT), $urandom_range(0, 4 * UNIT),
                        $urandom_range(0, 255), $urandom_range(0, 255), delta, skip);
    endfunction

    // every field random, any command
    function automatic sweep_beat_t noise_beat();
        sweep_beat_t b;
        b.cmd   = 1'($urandom);
        b.idx   = IDX_W'($urandom);
        b.x     = POS_W'($urandom);
        b.y     = POS_W'($urandom);
        b.w     = SIZE_W'($urandom);
        b.h     = SIZE_W'($urandom);
        b.lay   = 8'($urandom);
        b.msk   = 8'($urandom);
        b.kind  = KIND_W'($urandom);
        b.axis  = 1'($urandom);
        b.delta = DELTA_W'($urandom);
        b.skip  = SKIP_N'($urandom);
        return b;
    endfunction

    // offer one beat, at times after a random gap, and wait for accept
    task automatic offer(input sweep_beat_t b);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= b.cmd;
        s_entry_index   <= b.idx;
        s_box_x         <= b.x;
        s_box_y         <= b.y;
        s_box_width     <= b.w;
        s_box_height    <= b.h;
        s_layer_bits    <= b.lay;
        s_mask_bits     <= b.msk;
        s_entry_kind_in <= b.kind;
        s_axis          <= b.axis;
        s_delta         <= b.delta;
        s_skip_set      <= b.skip;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (b.cmd == CMD_WRITE) writes_sent++;
        else                    sweeps_sent++;
    endtask

    // result side ready pattern, with one long hold-off
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        while (stall_count < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and verdict
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed scene: fill every entry before the first query
        offer(mk_write(0, 10 * UNIT, 0, 2 * UNIT, 10 * UNIT, 1, 1, KIND_SOLID));
        offer(mk_write(1, 0, 20 * UNIT, 10 * UNIT, UNIT, 1, 1, KIND_ONEWAY));
        offer(mk_write(2, -6 * UNIT, 0, UNIT, 10 * UNIT, 1, 1, KIND_SPARE));
        offer(mk_write(3, -4 * UNIT, 0, UNIT, 10 * UNIT, 0, 0, KIND_SOLID));
        offer(mk_write(4, -8388608, -8388608, 1048575, 1048575, 255, 255, KIND_SOLID));
        offer(mk_write(5, 8388607, 8388607, 1048575, 1048575, 255, 255, KIND_SOLID));
        offer(mk_write(6, -10 * UNIT + 77, 0, 2 * UNIT + 200, 10 * UNIT, 2, 0,
                       KIND_SOLID));
        offer(mk_write(7, 0, -12 * UNIT + 130, 10 * UNIT, 2 * UNIT + 99, 1, 0,
                       KIND_SOLID));
        for (int i = 8; i < 15; i++)
            offer(mk_write(i, scene_pos(), scene_pos(), UNIT, UNIT, 255, 255,
                           KIND_EMPTY));
        offer(mk_write(15, -1, -1, 1048575, 1048575, 255, 255, KIND_EMPTY));

        // directed queries
        offer(mk_query(AXIS_H, 2 * UNIT + 128, 2 * UNIT + 64, 2 * UNIT + 40, 2 * UNIT,
                       1, 1, 20 * UNIT, 0));
        offer(mk_query(AXIS_H, 2 * UNIT + 128, 2 * UNIT + 64, 2 * UNIT + 40, 2 * UNIT,
                       1, 1, 20 * UNIT, 16'h0001));
        offer(mk_query(AXIS_H, 2 * UNIT + 128, 2 * UNIT, 2 * UNIT, 2 * UNIT,
                       1, 3, -20 * UNIT, 0));
        offer(mk_query(AXIS_V, 2 * UNIT, 2 * UNIT + 50, 2 * UNIT, 2 * UNIT + 17,
                       1, 1, 40 * UNIT, 0));
        offer(mk_query(AXIS_V, 2 * UNIT, 2 * UNIT + 50, 2 * UNIT, 2 * UNIT,
                       1, 1, -20 * UNIT, 0));
        // zero delta with the mover inside a wall but not its floored box
        offer(mk_query(AXIS_H, 10 * UNIT + 128, 2 * UNIT, 192, 2 * UNIT,
                       1, 1, 0, 0));
        offer(mk_query(AXIS_H, -8388608, -8388608, 1048575, 1048575,
                       255, 255, D_MAX, 0));
        offer(mk_query(AXIS_V, 8388607, 8388607, 0, 0, 0, 0, D_MIN, 16'hFFFF));
        // mover already overlapping a wall
        offer(mk_query(AXIS_H, 10 * UNIT + 128, 2 * UNIT, 2 * UNIT, 2 * UNIT,
                       255, 255, 20 * UNIT, 0));

        // random part: mostly scene traffic, a little noise
        for (int n = 0; n < RAND_BEATS; n++) begin
            int r;
            if (n >= RAND_BEATS - QUIET_TAIL) begin
                idle_pct = 0;
            end else if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 8;
                    2: idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 8)       offer(noise_beat());
            else if (r < 35) offer(scene_write());
            else             offer(scene_query());
        end
        s_valid <= 1'b0;

        // drain, one edge first so the last prediction is counted
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Summary: %0d table writes and %0d sweep queries, %0d queries clamped,",
                 writes_sent, sweeps_sent, clamped);
        $display("         with random gaps on both sides and one long result hold-off");
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
design/swc_pkg.sv
design/swc_table.sv
design/swc_eval.sv
design/swept_box_collision_clamp.sv
design/swc_checker.sv
bench/clamp_checker.sv
bench/swept_box_collision_clamp_test.sv
